@@ hw/rtl/column_stats_distinct_counter_assert.svh @@
// Assertion macros used by the column statistics datapath.
// Depends on nothing; the bodies are empty in synthesis builds.
`ifndef COLUMN_STATS_DISTINCT_COUNTER_ASSERT_SVH
`define COLUMN_STATS_DISTINCT_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CSDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CSDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define CSDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/csdc_pkg.sv @@
// Types and constants of the column statistics block.
// Used by the interfaces, the controller, the datapath and the top level.
package csdc_pkg;

    localparam int SAMPLE_W = 64;
    localparam int ROW_W    = 32;
    localparam int DIST_W   = 11;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [ROW_W-1:0]           row_count_t;
    typedef logic [DIST_W-1:0]          dist_count_t;

    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_en;
        logic update;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ctrl_status_t;

endpackage

@@ hw/rtl/csdc_item_if.sv @@
// Input channel of the column statistics block: one column value per beat.
// Depends on csdc_pkg.
interface csdc_item_if;
    import csdc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    scan_start;

    modport source (output valid, output sample, output scan_start, input ready);
    modport sink (input valid, input sample, input scan_start, output ready);
endinterface

@@ hw/rtl/csdc_result_if.sv @@
// Output channel of the column statistics block: one statistics record per beat.
// Depends on csdc_pkg.
interface csdc_result_if;
    import csdc_pkg::*;

    logic        valid;
    logic        ready;
    sample_t     col_max;
    sample_t     col_min;
    row_count_t  row_count;
    dist_count_t distinct_count;
    logic        set_overflow;

    modport source (
        output valid, output col_max, output col_min, output row_count,
        output distinct_count, output set_overflow, input ready
    );
    modport sink (
        input valid, input col_max, input col_min, input row_count,
        input distinct_count, input set_overflow, output ready
    );
endinterface

@@ hw/rtl/csdc_ctrl.sv @@
// Sequencer of the column statistics block: accept, set lookup, update, result.
// Depends on csdc_pkg.
module csdc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  csdc_pkg::ctrl_status_t status,
    output csdc_pkg::ctrl_cmd_t    cmd
);
    import csdc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.scan_en  = 1'b0;
        cmd.update   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/csdc_datapath.sv @@
// Datapath of the column statistics block: running min, max and row count,
// the distinct-value memory with its lookup walk, and the result register.
// Depends on csdc_pkg and column_stats_distinct_counter_assert.svh.
`include "column_stats_distinct_counter_assert.svh"

module csdc_datapath #(
    parameter int CAPACITY   = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  csdc_pkg::ctrl_cmd_t    cmd,
    output csdc_pkg::ctrl_status_t status,
    input  csdc_pkg::sample_t      sample,
    input  logic                   scan_start,
    input  logic                   out_ready,
    output logic                   out_valid,
    output csdc_pkg::sample_t      col_max,
    output csdc_pkg::sample_t      col_min,
    output csdc_pkg::row_count_t   row_count,
    output csdc_pkg::dist_count_t  distinct_count,
    output logic                   set_overflow
);
    import csdc_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Statistics registers.
    sample_t               max_reg, max_next;
    sample_t               min_reg, min_next;
    logic [COUNT_BITS-1:0] rows_reg, rows_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic                  ovf_reg, ovf_next;

    // Lookup walk registers.
    sample_t          sample_reg, sample_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             pend_reg, pend_next;
    logic             hit_reg, hit_next;
    sample_t          rd_data_reg;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    sample_t     out_max_reg;
    sample_t     out_min_reg;
    row_count_t  out_rows_reg;
    dist_count_t out_dist_reg;
    logic        out_ovf_reg;

    logic rd_en;
    logic wr_en;
    logic hit_now;

    logic [COUNT_BITS+ROW_W-1:0] rows_ext;
    logic [CNT_W+DIST_W-1:0]     total_ext;

    sample_t mem [CAPACITY];

    // A pending read returns the stored value that is compared with the sample.
    assign hit_now          = pend_reg && (rd_data_reg == sample_reg);
    assign status.scan_done = hit_now || (iss_reg == total_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign rows_ext  = {{ROW_W{1'b0}}, rows_reg};
    assign total_ext = {{DIST_W{1'b0}}, total_reg};

    // Next values of the statistics and of the lookup walk.
    always_comb
    begin
        max_next    = max_reg;
        min_next    = min_reg;
        rows_next   = rows_reg;
        total_next  = total_reg;
        ovf_next    = ovf_reg;
        sample_next = sample_reg;
        iss_next    = iss_reg;
        pend_next   = pend_reg;
        hit_next    = hit_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;

        if (cmd.accept)
        begin
            sample_next = sample;
            iss_next    = '0;
            pend_next   = 1'b0;
            hit_next    = 1'b0;
            if (scan_start)
            begin
                // A cleared scan leaves this value as both extremes.
                max_next   = sample;
                min_next   = sample;
                rows_next  = COUNT_BITS'(1);
                total_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                if (sample > max_reg)
                begin
                    max_next = sample;
                end
                if (sample < min_reg)
                begin
                    min_next = sample;
                end
                if (rows_reg != '1)
                begin
                    rows_next = rows_reg + COUNT_BITS'(1);
                end
            end
        end

        // Walk the stored entries, one read issued per cycle.
        if (cmd.scan_en)
        begin
            rd_en     = (iss_reg < total_reg);
            pend_next = rd_en;
            if (rd_en)
            begin
                iss_next = iss_reg + CNT_W'(1);
            end
            if (hit_now)
            begin
                hit_next = 1'b1;
            end
        end

        // Store a new value, or flag the overflow when the set is full.
        if (cmd.update && !hit_reg)
        begin
            if (total_reg < CAP_CNT)
            begin
                wr_en      = 1'b1;
                total_next = total_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // Result handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and statistics registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= SAMPLE_MIN;
            min_reg       <= SAMPLE_MAX;
            rows_reg      <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_reg       <= max_next;
            min_reg       <= min_next;
            rows_reg      <= rows_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            iss_reg       <= iss_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        if (cmd.load_out)
        begin
            out_max_reg  <= max_reg;
            out_min_reg  <= min_reg;
            out_rows_reg <= rows_ext[ROW_W-1:0];
            out_dist_reg <= total_ext[DIST_W-1:0];
            out_ovf_reg  <= ovf_reg;
        end
    end

    // Distinct-value memory: write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[total_reg[IDX_W-1:0]] <= sample_reg;
        end
    end

    // Distinct-value memory: registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[iss_reg[IDX_W-1:0]];
        end
    end

    assign out_valid      = out_valid_reg;
    assign col_max        = out_max_reg;
    assign col_min        = out_min_reg;
    assign row_count      = out_rows_reg;
    assign distinct_count = out_dist_reg;
    assign set_overflow   = out_ovf_reg;

    `CSDC_ASSERT_IMPL(a_total_bound, clk, rst_n, 1'b1, total_reg <= CAP_CNT, "set count past capacity")
    `CSDC_ASSERT_IMPL(a_walk_bound, clk, rst_n, 1'b1, iss_reg <= total_reg, "lookup walk past set end")
    `CSDC_ASSERT_IMPL(a_write_room, clk, rst_n, wr_en, total_reg < CAP_CNT, "write into a full set")
    `CSDC_ASSERT_IMPL(a_ovf_full, clk, rst_n, ovf_reg, total_reg == CAP_CNT, "overflow with room left")
    `CSDC_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.load_out, out_valid_reg, "result not shown")

endmodule

@@ hw/rtl/column_stats_distinct_counter.sv @@
// Column statistics with exact distinct count: one result beat per input beat.
// Each input beat walks the values held in the set, then updates the set and loads the result.
// No new beat is taken before the result is loaded, which waits while the result register waits on ready.
// A hit on an earlier entry ends the walk early; a scan start empties the set at once.
// Reset (rst_n low, asynchronous) clears the running statistics; the memory and the result payload are not cleared.
// Depends on csdc_pkg, csdc_item_if, csdc_result_if, csdc_ctrl and csdc_datapath.
module column_stats_distinct_counter #(
    parameter int CAPACITY   = 1024,
    parameter int COUNT_BITS = 32
) (
    input logic          clk,
    input logic          rst_n,
    csdc_item_if.sink    item,
    csdc_result_if.source result
);
    import csdc_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // Sequencer.
    csdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Statistics, set memory and result register.
    csdc_datapath #(
        .CAPACITY   (CAPACITY),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample         (item.sample),
        .scan_start     (item.scan_start),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .col_max        (result.col_max),
        .col_min        (result.col_min),
        .row_count      (result.row_count),
        .distinct_count (result.distinct_count),
        .set_overflow   (result.set_overflow)
    );

endmodule
